### design/psd_pkg.sv
// psd_pkg: shared widths, region codes, job and payload types for point_segment_distance
// no dependencies; imported by every module of the block
package psd_pkg;

  localparam int CW = 32;
  localparam int IN_W = 9 * CW;
  localparam int OUT_W = 4 * CW;
  localparam int D_W = CW + 1;
  localparam int PR_W = 2 * D_W;
  localparam int L2_W = 2 * CW + 2;
  localparam int DOT_W = L2_W + 1;
  localparam int QB = CW + 1;
  localparam int NUM_W = L2_W + D_W;
  localparam int R_W = L2_W + QB;
  localparam int OFF_W = QB + 1;
  localparam int Q_W = CW + 3;
  localparam int DF_W = CW + 3;
  localparam int SUM_W = 2 * DF_W;
  localparam int RT_W = DF_W;
  localparam int T_W = SUM_W + 2;
  localparam int DIV_LAT = QB + 1;
  localparam int B_LAT = DIV_LAT + RT_W + 7;
  localparam int QDEPTH = 4;
  localparam int QP_W = 2;
  localparam int REG_W = 2;

  localparam logic [REG_W-1:0] REG_DEGEN = 2'd0;
  localparam logic [REG_W-1:0] REG_BEFORE = 2'd1;
  localparam logic [REG_W-1:0] REG_BEYOND = 2'd2;
  localparam logic [REG_W-1:0] REG_WITHIN = 2'd3;

  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][D_W-1:0] d;
    logic [2:0][D_W-1:0] w;
    logic dot_neg;
    logic [REG_W-1:0] region;
  } psd_ctx_t;

  typedef struct packed {
    psd_ctx_t ctx;
    logic [L2_W-1:0] l2;
    logic [L2_W-1:0] dmag;
  } psd_job_t;

  typedef struct packed {
    logic [2:0][CW-1:0] proj;
    logic [REG_W-1:0] region;
  } psd_pay_t;

  function automatic logic [CW-1:0] sat_coord(input logic [Q_W-1:0] v);
    logic [Q_W-CW:0] top;
    logic [CW-1:0] r;
    top = v[Q_W-1:CW-1];
    if (top == '0 || top == '1) begin
      r = v[CW-1:0];
    end else if (v[Q_W-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### design/psd_front.sv
// psd_front: accepts query beats, forms edge and offset vectors, squared length and dot product
// classifies the projection and hands a job to the queue; uses psd_pkg
module psd_front import psd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  output logic            push,
  output psd_job_t        job,
  input  logic            full
);

  logic en;
  logic v1, v2, v3;
  logic [2:0][CW-1:0] s1, s2, s3;
  logic [2:0][D_W-1:0] d1, w1, d2, w2, d3, w3;
  logic [2:0][PR_W-1:0] dd2, dw2;
  logic [DOT_W-1:0] l2_3, dot3;
  logic [DOT_W-1:0] dabs;
  logic [L2_W-1:0] l2v, dmag;
  logic dneg;

  assign en = !v3 || !full;
  assign in_ready = en;
  assign push = v3 && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= in_data[(3+i)*CW +: CW];
        d1[i] <= D_W'($signed(in_data[(6+i)*CW +: CW])) - D_W'($signed(in_data[(3+i)*CW +: CW]));
        w1[i] <= D_W'($signed(in_data[i*CW +: CW])) - D_W'($signed(in_data[(3+i)*CW +: CW]));
        dd2[i] <= PR_W'($signed(d1[i])) * PR_W'($signed(d1[i]));
        dw2[i] <= PR_W'($signed(d1[i])) * PR_W'($signed(w1[i]));
      end
      s2 <= s1;
      d2 <= d1;
      w2 <= w1;
      l2_3 <= DOT_W'($signed(dd2[0])) + DOT_W'($signed(dd2[1])) + DOT_W'($signed(dd2[2]));
      dot3 <= DOT_W'($signed(dw2[0])) + DOT_W'($signed(dw2[1])) + DOT_W'($signed(dw2[2]));
      s3 <= s2;
      d3 <= d2;
      w3 <= w2;
    end
  end

  always_comb begin
    dneg = dot3[DOT_W-1];
    dabs = dneg ? (~dot3 + 1'b1) : dot3;
    dmag = dabs[L2_W-1:0];
    l2v = l2_3[L2_W-1:0];
    job.ctx.s = s3;
    job.ctx.d = d3;
    job.ctx.w = w3;
    job.ctx.dot_neg = dneg;
    job.l2 = l2v;
    job.dmag = dmag;
    if (l2v == '0) begin
      job.ctx.region = REG_DEGEN;
    end else if (dneg) begin
      job.ctx.region = REG_BEFORE;
    end else if (dmag > l2v) begin
      job.ctx.region = REG_BEYOND;
    end else begin
      job.ctx.region = REG_WITHIN;
    end
  end

endmodule

### design/psd_fifo.sv
// psd_fifo: short job queue between the front and back pipelines
// flop storage, one write and one read port; uses psd_pkg
module psd_fifo import psd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  psd_job_t wdata,
  output logic     full,
  input  logic     pop,
  output psd_job_t rdata,
  output logic     empty
);

  psd_job_t mem [QDEPTH];
  logic [QP_W-1:0] wp, rp;
  logic [QP_W:0] cnt;

  assign full = cnt == (QP_W+1)'(QDEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule

### design/psd_div.sv
// psd_div: pipelined restoring divider, one quotient bit per stage, rounded to nearest
// gives the projection offset magnitude; uses psd_pkg
module psd_div import psd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [L2_W-1:0]  den,
  output logic [OFF_W-1:0] off
);

  logic [R_W-1:0] r_q [QB];
  logic [QB-1:0] q_q [QB];
  logic [L2_W-1:0] d_q [QB];
  logic rnd;

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [R_W-1:0] r_in, dsh;
    logic [QB-1:0] q_in;
    logic [L2_W-1:0] d_in;
    logic ge;
    if (j == 0) begin : g_first
      assign r_in = R_W'(num);
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign q_in = q_q[j-1];
      assign d_in = d_q[j-1];
    end
    assign dsh = R_W'(d_in) << B;
    assign ge = r_in >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        r_q[j] <= ge ? r_in - dsh : r_in;
        q_q[j] <= ge ? (q_in | (QB'(1) << B)) : q_in;
        d_q[j] <= d_in;
      end
    end
  end

  assign rnd = {r_q[QB-1][L2_W-1:0], 1'b0} >= {1'b0, d_q[QB-1]};

  always_ff @(posedge clk) begin
    if (en) off <= OFF_W'(q_q[QB-1]) + OFF_W'(rnd);
  end

endmodule

### design/psd_back.sv
// psd_back: projection numerator, three dividers, projection, squared distance and square root
// pipelined under one stall enable, output register at the end; uses psd_pkg and psd_div
module psd_back import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  output logic             pop,
  input  psd_job_t         job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic [REG_W-1:0] out_user
);

  logic be;
  logic [B_LAT-1:0] vsh;
  psd_job_t j0;
  logic [2:0][D_W-1:0] ad0;
  psd_ctx_t c1, c2;
  logic [L2_W-1:0] l2_1, l2_2;
  logic [2:0][PR_W-1:0] pl1, ph1;
  logic [2:0][NUM_W-1:0] num2;
  logic [2:0][OFF_W-1:0] off;
  psd_ctx_t cd [DIV_LAT];
  psd_ctx_t cx;
  logic [2:0][Q_W-1:0] q_c, q3;
  logic [2:0][DF_W-1:0] df_c, df3, ax3;
  logic [REG_W-1:0] reg3;
  logic [2:0][SUM_W-1:0] sq4;
  psd_pay_t pay4, pay5;
  logic [SUM_W-1:0] sum5;
  logic [SUM_W-1:0] rm_q [RT_W];
  logic [RT_W-1:0] rt_q [RT_W];
  psd_pay_t py_q [RT_W];
  logic [CW-1:0] od;
  psd_pay_t opay;

  assign be = !out_valid || out_ready;
  assign pop = be && !empty;
  assign out_valid = vsh[B_LAT-1];
  assign out_data = {opay.proj, od};
  assign out_user = opay.region;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsh <= '0;
    end else if (be) begin
      vsh <= {vsh[B_LAT-2:0], pop};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad0[i] = j0.ctx.d[i][D_W-1] ? (~j0.ctx.d[i] + 1'b1) : j0.ctx.d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      j0 <= job;
      for (int i = 0; i < 3; i++) begin
        pl1[i] <= PR_W'(j0.dmag[D_W-1:0]) * PR_W'(ad0[i]);
        ph1[i] <= PR_W'(j0.dmag[L2_W-1:D_W]) * PR_W'(ad0[i]);
        num2[i] <= NUM_W'(pl1[i]) + (NUM_W'(ph1[i]) << D_W);
      end
      c1 <= j0.ctx;
      l2_1 <= j0.l2;
      c2 <= c1;
      l2_2 <= l2_1;
      cd[0] <= c2;
      for (int k = 1; k < DIV_LAT; k++) cd[k] <= cd[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    psd_div u_div (
      .clk (clk),
      .en  (be),
      .num (num2[i]),
      .den (l2_2),
      .off (off[i])
    );
  end

  assign cx = cd[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic neg;
      logic [Q_W-1:0] so, sgo;
      logic [DF_W-1:0] we, de;
      neg = cx.dot_neg ^ cx.d[i][D_W-1];
      so = Q_W'($signed(cx.s[i]));
      sgo = neg ? (~Q_W'(off[i]) + 1'b1) : Q_W'(off[i]);
      we = DF_W'($signed(cx.w[i]));
      de = DF_W'($signed(cx.d[i]));
      q_c[i] = (cx.region == REG_DEGEN) ? so : so + sgo;
      case (cx.region)
        REG_WITHIN: df_c[i] = we - sgo;
        REG_BEYOND: df_c[i] = we - de;
        default:    df_c[i] = we;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax3[i] = df3[i][DF_W-1] ? (~df3[i] + 1'b1) : df3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      q3 <= q_c;
      df3 <= df_c;
      reg3 <= cx.region;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= SUM_W'(ax3[i]) * SUM_W'(ax3[i]);
        pay4.proj[i] <= sat_coord(q3[i]);
      end
      pay4.region <= reg3;
      sum5 <= sq4[0] + sq4[1] + sq4[2];
      pay5 <= pay4;
    end
  end

  for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
    localparam int B = RT_W - 1 - j;
    logic [SUM_W-1:0] rm_in;
    logic [RT_W-1:0] rt_in;
    psd_pay_t py_in;
    logic [T_W-1:0] trial;
    logic ge;
    if (j == 0) begin : g_first
      assign rm_in = sum5;
      assign rt_in = '0;
      assign py_in = pay5;
    end else begin : g_next
      assign rm_in = rm_q[j-1];
      assign rt_in = rt_q[j-1];
      assign py_in = py_q[j-1];
    end
    assign trial = (T_W'(rt_in) << (B + 1)) | (T_W'(1) << (2 * B));
    assign ge = T_W'(rm_in) >= trial;
    always_ff @(posedge clk) begin
      if (be) begin
        rm_q[j] <= ge ? rm_in - trial[SUM_W-1:0] : rm_in;
        rt_q[j] <= ge ? (rt_in | (RT_W'(1) << B)) : rt_in;
        py_q[j] <= py_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      od <= (rt_q[RT_W-1][RT_W-1:CW] != '0) ? '1 : rt_q[RT_W-1][CW-1:0];
      opay <= py_q[RT_W-1];
    end
  end

endmodule

### design/point_segment_distance.sv
// point_segment_distance: top level, front pipeline, job queue and back pipeline
// uses psd_pkg, psd_front, psd_fifo, psd_back
//
// Distance from a 3-D point to a segment in signed Q16.16, with the unclamped projection onto
// the segment's line and a region code (0 degenerate, 1 before start, 2 beyond end, 3 within).
// Distance saturates to all ones, the projection to the signed range. One query beat is taken
// every clock unless a full queue stalls the front pipeline; each result passes through a
// divider pipeline per axis and the 35-stage square-root pipeline. A four-entry queue sits between
// the front and back halves, so input keeps flowing for a few beats while the output is held off.
module point_segment_distance import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // point_x, point_y, point_z, seg_start_x/y/z, seg_end_x/y/z, 32 bits each
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // distance, proj_x, proj_y, proj_z, 32 bits each
  output logic [OUT_W-1:0] m_axis_tdata,
  // region
  output logic [REG_W-1:0] m_axis_tuser
);

  logic push, full, pop, empty;
  psd_job_t job_in, job_out;

  psd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .push     (push),
    .job      (job_in),
    .full     (full)
  );

  psd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (pop),
    .rdata (job_out),
    .empty (empty)
  );

  psd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop       (pop),
    .job       (job_out),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule
